/* sv/modexp_pkg.sv */
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared types and constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
`default_nettype none

package modexp_pkg;

	localparam int OPERAND_WIDTH = 32;
	localparam int CNT_W = $clog2(OPERAND_WIDTH);
	localparam logic [OPERAND_WIDTH-1:0] MODULUS_RESET = OPERAND_WIDTH'(1000000007);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_CHECK,
		ST_MUL,
		ST_SQR
	} state_t;

endpackage

`default_nettype wire

/* sv/modular_exponentiation.sv */
// ----------------------------------------------------------------------------
// modular_exponentiation
// base ** exponent mod modulus by right-to-left square-and-multiply, with
// every modular product formed by shift-and-add on one step unit.
// ----------------------------------------------------------------------------
// An item (base, exponent) is taken when start is high and busy is low; its
// result appears on power_result for exactly one cycle with done high and
// must be captured then, as the block cannot be held off. When modulus is
// below 2, the item goes from the accept straight to a decision step that
// produces a result of zero. Otherwise the base is first reduced modulo
// modulus, then for each exponent bit up to the highest set one there is
// a decision step, a multiply when the bit is set and a square when higher
// bits remain. A final decision step then delivers the result. The single
// modular step unit takes one multiplier bit per cycle. busy stays high
// until the result cycle. The user must write modulus through modulus_we
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module modular_exponentiation (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                modulus_we,
	input  wire logic [modexp_pkg::OPERAND_WIDTH-1:0] modulus,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [modexp_pkg::OPERAND_WIDTH-1:0] base,
	input  wire logic [modexp_pkg::OPERAND_WIDTH-1:0] exponent,
	output logic                                     done,
	output logic [modexp_pkg::OPERAND_WIDTH-1:0]      power_result
);

	localparam int W = modexp_pkg::OPERAND_WIDTH;
	localparam int CW = modexp_pkg::CNT_W;

	modexp_pkg::state_t state_q, state_d;

	logic [W-1:0] m_q;
	logic [W-1:0] x_q, x_d;
	logic [W-1:0] e_q, e_d;
	logic [W-1:0] acc_q, acc_d;
	logic [W-1:0] p_q, p_d;
	logic [W-1:0] a_q, a_d;
	logic [W-1:0] b_q, b_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          done_q, done_d;
	logic [W-1:0] res_q, res_d;

	logic [W-1:0] add_op;
	logic          add_cin;
	logic [W-1:0] p_step;
	logic [W-1:0] a_step;
	logic [W-1:0] b_step;
	logic          last_step;
	logic          reducing;

	// x + y + cin with one conditional subtract; valid while x + y + cin < 2m
	function automatic logic [W-1:0] mod_add(input logic [W-1:0] x, input logic [W-1:0] y,
			input logic cin, input logic [W-1:0] m);
		logic [W:0] sum;
		logic [W:0] mx;
		sum = {1'b0, x} + {1'b0, y} + {{W{1'b0}}, cin};
		mx = {1'b0, m};
		if (sum >= mx) begin
			sum = sum - mx;
		end
		return sum[W-1:0];
	endfunction

	// shared step unit: reduce doubles p and shifts in a base bit,
	// multiply adds the multiplicand on a set multiplier bit and doubles it
	assign reducing = (state_q == modexp_pkg::ST_REDUCE);
	assign add_op = reducing ? p_q : (b_q[0] ? a_q : '0);
	assign add_cin = reducing ? b_q[W-1] : 1'b0;
	assign p_step = mod_add(p_q, add_op, add_cin, m_q);
	assign a_step = mod_add(a_q, a_q, 1'b0, m_q);
	assign b_step = reducing ? {b_q[W-2:0], 1'b0} : {1'b0, b_q[W-1:1]};
	assign last_step = (cnt_q == CW'(W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= modexp_pkg::ST_IDLE;
			m_q <= modexp_pkg::MODULUS_RESET;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			done_q <= done_d;
			cnt_q <= cnt_d;
			if (modulus_we) begin
				m_q <= modulus;
			end
		end
	end

	always_ff @(posedge clk) begin
		x_q <= x_d;
		e_q <= e_d;
		acc_q <= acc_d;
		p_q <= p_d;
		a_q <= a_d;
		b_q <= b_d;
		res_q <= res_d;
	end

	always_comb begin
		state_d = state_q;
		x_d = x_q;
		e_d = e_q;
		acc_d = acc_q;
		p_d = p_q;
		a_d = a_q;
		b_d = b_q;
		cnt_d = cnt_q;
		done_d = 1'b0;
		res_d = res_q;

		unique case (state_q)
			modexp_pkg::ST_IDLE: begin
				if (start) begin
					if (m_q < W'(2)) begin
						// no residue beyond zero: finish through the check
						acc_d = '0;
						e_d = '0;
						state_d = modexp_pkg::ST_CHECK;
					end else begin
						e_d = exponent;
						p_d = '0;
						b_d = base;
						cnt_d = '0;
						state_d = modexp_pkg::ST_REDUCE;
					end
				end
			end
			modexp_pkg::ST_REDUCE: begin
				p_d = p_step;
				b_d = b_step;
				cnt_d = cnt_q + CW'(1);
				if (last_step) begin
					x_d = p_step;
					acc_d = W'(1);
					state_d = modexp_pkg::ST_CHECK;
				end
			end
			modexp_pkg::ST_CHECK: begin
				p_d = '0;
				a_d = x_q;
				cnt_d = '0;
				if (e_q == '0) begin
					done_d = 1'b1;
					res_d = acc_q;
					state_d = modexp_pkg::ST_IDLE;
				end else if (e_q[0]) begin
					b_d = acc_q;
					state_d = modexp_pkg::ST_MUL;
				end else begin
					b_d = x_q;
					state_d = modexp_pkg::ST_SQR;
				end
			end
			modexp_pkg::ST_MUL: begin
				p_d = p_step;
				a_d = a_step;
				b_d = b_step;
				cnt_d = cnt_q + CW'(1);
				if (last_step) begin
					acc_d = p_step;
					if (e_q[W-1:1] != '0) begin
						p_d = '0;
						a_d = x_q;
						b_d = x_q;
						cnt_d = '0;
						state_d = modexp_pkg::ST_SQR;
					end else begin
						// top bit used: skip the square nobody needs
						e_d = '0;
						state_d = modexp_pkg::ST_CHECK;
					end
				end
			end
			modexp_pkg::ST_SQR: begin
				p_d = p_step;
				a_d = a_step;
				b_d = b_step;
				cnt_d = cnt_q + CW'(1);
				if (last_step) begin
					x_d = p_step;
					e_d = {1'b0, e_q[W-1:1]};
					state_d = modexp_pkg::ST_CHECK;
				end
			end
			default: begin
				state_d = modexp_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != modexp_pkg::ST_IDLE);
	assign done = done_q;
	assign power_result = res_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without an item in progress");

	a_partial_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == modexp_pkg::ST_MUL || state_q == modexp_pkg::ST_SQR) |->
			(p_q < m_q) && (a_q < m_q))
		else $error("partial product or multiplicand not reduced");

	a_reduce_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == modexp_pkg::ST_REDUCE) |-> (p_q < m_q))
		else $error("base remainder not reduced");

endmodule

`default_nettype wire
